/* design/brti_pkg.sv */
// brti_pkg: shared types and constants for the briere rate trapezoid integrator
// holds the queue item layout, back-end state encoding, config register codes and reset values
// no dependencies
`default_nettype none

package brti_pkg;

  localparam int unsigned INTEGRAL_WIDTH_DEF = 48;
  localparam int unsigned QUEUE_DEPTH        = 2;
  localparam int unsigned ROOT_STEPS         = 16;
  localparam int unsigned ROOT_CNT_W         = 4;
  localparam int unsigned CFG_INDEX_W        = 2;

  // configuration register codes
  localparam logic [CFG_INDEX_W-1:0] CFG_RATE_COEFFICIENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOWER_THRESHOLD  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_THRESHOLD  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIME_STEP        = 2'd3;

  localparam logic [31:0] RST_RATE_COEFFICIENT = 32'd565800;
  localparam logic [15:0] RST_LOWER_THRESHOLD  = 16'd2626;
  localparam logic [15:0] RST_UPPER_THRESHOLD  = 16'd9383;
  localparam logic [15:0] RST_TIME_STEP        = 16'd64;

  // classified sample as it travels from front to back
  typedef struct packed {
    logic        in_window;
    logic        series_start;
    logic [14:0] magnitude;
    logic [15:0] lower_gap;
    logic [15:0] upper_gap;
  } brti_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_MUL_P,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_RATE,
    ST_INTEG,
    ST_DEV,
    ST_FIN
  } back_state_t;

endpackage

`default_nettype wire

/* design/brti_front.sv */
// brti_front: input handshake and sample classification
// checks the temperature window and forms the gaps for the back end; uses brti_pkg
`default_nettype none

module brti_front (
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [15:0]       in_temperature,
  input  wire logic                     in_series_start,
  input  wire logic [15:0]              lower_threshold,
  input  wire logic [15:0]              upper_threshold,
  input  wire logic                     queue_full,
  output logic                          push,
  output brti_pkg::brti_item_t          push_item
);
  import brti_pkg::*;

  logic signed [16:0] t_x;
  logic signed [16:0] lo_x;
  logic signed [16:0] hi_x;
  logic signed [16:0] gap_lo;
  logic signed [16:0] gap_hi;

  assign t_x    = {in_temperature[15], in_temperature};
  assign lo_x   = {lower_threshold[15], lower_threshold};
  assign hi_x   = {upper_threshold[15], upper_threshold};
  assign gap_lo = t_x - lo_x;
  assign gap_hi = hi_x - t_x;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // negative samples inside the window clamp to zero rate, so they count as outside
  always_comb begin
    push_item.in_window    = (t_x > lo_x) && (t_x <= hi_x) && (t_x > 17'sd0);
    push_item.series_start = in_series_start;
    push_item.magnitude    = in_temperature[14:0];
    push_item.lower_gap    = gap_lo[15:0];
    push_item.upper_gap    = gap_hi[15:0];
  end

endmodule

`default_nettype wire

/* design/brti_queue.sv */
// brti_queue: short fifo of classified samples between front and back
// register based, depth from brti_pkg
`default_nettype none

module brti_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire brti_pkg::brti_item_t push_item,
  output logic                      full,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output brti_pkg::brti_item_t      pop_item
);
  import brti_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  brti_item_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* design/brti_back.sv */
// brti_back: sequencer that computes the briere rate, the trapezoid sum and the scaled output
// bit-serial square root, chained multiplies, saturating accumulate, output register; uses brti_pkg
`default_nettype none

module brti_back #(
  parameter int unsigned INTEGRAL_WIDTH = brti_pkg::INTEGRAL_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 pop_valid,
  output logic                      pop_ready,
  input  wire brti_pkg::brti_item_t pop_item,
  input  wire logic [31:0]          rate_coefficient,
  input  wire logic [15:0]          time_step,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [31:0]               out_rate,
  output logic [31:0]               out_development
);
  import brti_pkg::*;

  localparam int unsigned HI_W  = INTEGRAL_WIDTH - 32;
  localparam int unsigned TOT_W = INTEGRAL_WIDTH + 17;

  back_state_t state_r, state_nxt;

  logic [ROOT_CNT_W-1:0]     step_cnt_r;
  logic                      start_r;
  logic                      window_r;
  logic [14:0]               mag_r;
  logic [15:0]               d1_r;
  logic [31:0]               x_r;
  logic [31:0]               root_r;
  logic [31:0]               bit_r;
  logic [30:0]               m1_r;
  logic [46:0]               p_r;
  logic [62:0]               ph_r;
  logic [62:0]               pl_r;
  logic [31:0]               rate_r;
  logic [31:0]               prev_r;
  logic                      have_prev_r;
  logic [INTEGRAL_WIDTH-1:0] integral_r;
  logic [47:0]               lo_prod_r;
  logic [HI_W+15:0]          hi_prod_r;
  logic                      out_valid_r;
  logic [31:0]               out_rate_r;
  logic [31:0]               out_development_r;

  logic [32:0]               trial;
  logic                      trial_fits;
  logic [63:0]               q_sum;
  logic [43:0]               q;
  logic [31:0]               rate_sat;
  logic [32:0]               pair_sum;
  logic [INTEGRAL_WIDTH:0]   acc_sum;
  logic [TOT_W-1:0]          total;
  logic [31:0]               dev_sat;
  logic                      out_free;

  assign pop_ready       = (state_r == ST_IDLE);
  assign out_free        = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_rate        = out_rate_r;
  assign out_development = out_development_r;

  // one restoring square-root step per cycle
  assign trial      = {1'b0, root_r} + {1'b0, bit_r};
  assign trial_fits = ({1'b0, x_r} >= trial);

  // floor(p * a / 2^36) from the two 16-bit halves of a
  assign q_sum    = {1'b0, ph_r} + {17'b0, pl_r[62:16]};
  assign q        = q_sum[63:20];
  assign rate_sat = (|q[43:32]) ? 32'hFFFF_FFFF : q[31:0];

  assign pair_sum = {1'b0, prev_r} + {1'b0, rate_r};
  assign acc_sum  = {1'b0, integral_r} + {{(INTEGRAL_WIDTH - 32){1'b0}}, pair_sum};

  assign total   = {1'b0, hi_prod_r, 32'b0} + {{(TOT_W - 48){1'b0}}, lo_prod_r};
  assign dev_sat = (|total[TOT_W-1:49]) ? 32'hFFFF_FFFF : total[48:17];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          state_nxt = pop_item.in_window ? ST_SQRT : ST_RATE;
        end
      end
      ST_SQRT: begin
        if (step_cnt_r == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P:  state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_RATE;
      ST_RATE:   state_nxt = ST_INTEG;
      ST_INTEG:  state_nxt = ST_DEV;
      ST_DEV:    state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_cnt_r  <= '0;
      have_prev_r <= 1'b0;
      prev_r      <= '0;
      integral_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SQRT) begin
        step_cnt_r <= step_cnt_r + 1'b1;
      end else begin
        step_cnt_r <= '0;
      end
      if (state_r == ST_INTEG) begin
        // first sample of a series, or the first since reset, restarts the sum
        if (start_r || !have_prev_r) begin
          integral_r <= '0;
        end else if (acc_sum[INTEGRAL_WIDTH]) begin
          integral_r <= '1;
        end else begin
          integral_r <= acc_sum[INTEGRAL_WIDTH-1:0];
        end
        prev_r      <= rate_r;
        have_prev_r <= 1'b1;
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          start_r  <= pop_item.series_start;
          window_r <= pop_item.in_window;
          mag_r    <= pop_item.magnitude;
          d1_r     <= pop_item.lower_gap;
          x_r      <= {pop_item.upper_gap, 16'b0};
          root_r   <= '0;
          bit_r    <= 32'h4000_0000;
        end
      end
      ST_SQRT: begin
        if (trial_fits) begin
          x_r    <= x_r - trial[31:0];
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        m1_r  <= {16'b0, mag_r} * {15'b0, d1_r};
      end
      ST_MUL_P: begin
        p_r <= {16'b0, m1_r} * {31'b0, root_r[15:0]};
      end
      ST_MUL_HI: begin
        ph_r <= {16'b0, p_r} * {47'b0, rate_coefficient[31:16]};
      end
      ST_MUL_LO: begin
        pl_r <= {16'b0, p_r} * {47'b0, rate_coefficient[15:0]};
      end
      ST_RATE: begin
        rate_r <= window_r ? rate_sat : 32'd0;
      end
      ST_INTEG: begin
      end
      ST_DEV: begin
        lo_prod_r <= {16'b0, integral_r[31:0]} * {32'b0, time_step};
        hi_prod_r <= {16'b0, integral_r[INTEGRAL_WIDTH-1:32]} * {{HI_W{1'b0}}, time_step};
      end
      ST_FIN: begin
        if (out_free) begin
          out_rate_r        <= rate_r;
          out_development_r <= dev_sat;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/briere_rate_trapezoid_integrator_core.sv */
// briere rate trapezoid integrator: one result per temperature sample
// the back end handles one sample at a time: in window it runs a 16-step square root and a
// multiply chain before the rate, integrate and output steps; samples outside it skip both
// a 2-entry queue lets the input side take samples while the back end works or the result waits
// reset (synchronous, active low) loads register defaults and clears the running integral
`default_nettype none

module briere_rate_trapezoid_integrator_core #(
  parameter int unsigned INTEGRAL_WIDTH = brti_pkg::INTEGRAL_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [brti_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [31:0]                       cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [15:0]                in_temperature,
  input  wire logic                              in_series_start,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [31:0]                            out_rate,
  output logic [31:0]                            out_development
);
  import brti_pkg::*;

  logic [31:0] rate_coefficient_r;
  logic [15:0] lower_threshold_r;
  logic [15:0] upper_threshold_r;
  logic [15:0] time_step_r;

  logic        queue_full;
  logic        push;
  brti_item_t  push_item;
  logic        pop_valid;
  logic        pop_ready;
  brti_item_t  pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_coefficient_r <= RST_RATE_COEFFICIENT;
      lower_threshold_r  <= RST_LOWER_THRESHOLD;
      upper_threshold_r  <= RST_UPPER_THRESHOLD;
      time_step_r        <= RST_TIME_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RATE_COEFFICIENT: rate_coefficient_r <= cfg_wdata;
        CFG_LOWER_THRESHOLD:  lower_threshold_r  <= cfg_wdata[15:0];
        CFG_UPPER_THRESHOLD:  upper_threshold_r  <= cfg_wdata[15:0];
        CFG_TIME_STEP:        time_step_r        <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  brti_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_temperature  (in_temperature),
    .in_series_start (in_series_start),
    .lower_threshold (lower_threshold_r),
    .upper_threshold (upper_threshold_r),
    .queue_full      (queue_full),
    .push            (push),
    .push_item       (push_item)
  );

  brti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  brti_back #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .rate_coefficient (rate_coefficient_r),
    .time_step        (time_step_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rate         (out_rate),
    .out_development  (out_development)
  );

endmodule

`default_nettype wire
